>>> hdl/phong_point_light_shade_core_assert.svh
// Assertion macros shared by the shading core.
`ifndef PHONG_POINT_LIGHT_SHADE_CORE_ASSERT_SVH
`define PHONG_POINT_LIGHT_SHADE_CORE_ASSERT_SVH

// Implication in the same cycle, sampled on the rising clock edge.
`define PPS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("shading core check failed");

// Implication in the next cycle.
`define PPS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("shading core check failed");

`endif

>>> hdl/pps_pkg.sv
// Shared types, constants and helper functions of the shading core.
package pps_pkg;

	localparam logic [14:0] ONE_Q14    = 15'd16384;
	localparam logic [15:0] FULL_Q8    = 16'd65280;
	localparam logic [16:0] RATIO_MAX  = 17'd65536;
	// Reciprocal of 255 scaled by 2^39, exact for dividends below 2^32.
	localparam logic [31:0] RECIP_255  = 32'h80808081;
	localparam int          RECIP_SHIFT = 39;
	// Half of 255 * 2^22, the rounding term of the colour scaling.
	localparam logic [49:0] COL_ROUND  = 50'd534773760;
	localparam int          FACT_W     = 42;

	typedef enum logic [2:0] {
		REG_LIGHT_POS_X = 3'd0,
		REG_LIGHT_POS_Y = 3'd1,
		REG_LIGHT_POS_Z = 3'd2,
		REG_LIGHT_RED   = 3'd3,
		REG_LIGHT_GREEN = 3'd4,
		REG_LIGHT_BLUE  = 3'd5,
		REG_LIGHT_RATIO = 3'd6
	} reg_idx_t;

	typedef logic signed [15:0] q14_t;

	// Per-item data that rides alongside the light direction pipeline.
	typedef struct {
		q14_t        nrm [3];
		q14_t        view [3];
		logic [23:0] surface;
		logic [23:0] ambient;
		logic        shadow;
	} side_t;

	function automatic logic [5:0] msb_pos(input logic [32:0] m);
		logic [5:0] p;
		p = 6'd0;
		for (int i = 0; i < 33; i++) begin
			if (m[i]) begin
				p = 6'(i);
			end
		end
		return p;
	endfunction

	// Clamp a Q.28 dot product to [0, 1.0] in Q1.14, rounding half up.
	function automatic logic [14:0] sat_factor(input logic signed [FACT_W-1:0] d);
		logic [FACT_W-1:0] f;
		f = '0;
		if (d <= 0) begin
			return 15'd0;
		end
		f = (FACT_W'(unsigned'(d)) + FACT_W'(8192)) >> 14;
		if (f > FACT_W'(ONE_Q14)) begin
			return ONE_Q14;
		end
		return 15'(f);
	endfunction

endpackage

>>> hdl/pps_ifs.sv
// Stream interfaces for hit points in and shaded colours out.
interface pps_hit_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] hit_x;
	logic signed [31:0] hit_y;
	logic signed [31:0] hit_z;
	logic signed [15:0] normal_x;
	logic signed [15:0] normal_y;
	logic signed [15:0] normal_z;
	logic signed [15:0] view_x;
	logic signed [15:0] view_y;
	logic signed [15:0] view_z;
	logic [23:0]        surface_rgb;
	logic [23:0]        ambient_rgb;
	logic               in_shadow;

	modport source (output valid, hit_x, hit_y, hit_z, normal_x, normal_y, normal_z,
		view_x, view_y, view_z, surface_rgb, ambient_rgb, in_shadow, input ready);
	modport sink (input valid, hit_x, hit_y, hit_z, normal_x, normal_y, normal_z,
		view_x, view_y, view_z, surface_rgb, ambient_rgb, in_shadow, output ready);
endinterface

interface pps_shade_if;
	logic        valid;
	logic        ready;
	logic [15:0] out_red;
	logic [15:0] out_green;
	logic [15:0] out_blue;

	modport source (output valid, out_red, out_green, out_blue, input ready);
	modport sink (input valid, out_red, out_green, out_blue, output ready);
endinterface

>>> hdl/pps_ldir.sv
// Light direction unit: normalise, pipelined square root and per-lane division.
module pps_ldir (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               in_v,
	input  logic signed [31:0] hit [3],
	input  logic signed [31:0] lpos [3],
	input  pps_pkg::side_t     side_in,
	output logic               out_v,
	output pps_pkg::q14_t      dir [3],
	output pps_pkg::side_t     side_out
);

	localparam int SQ_STEPS  = 31;
	localparam int DIV_STEPS = 15;

	// Stage 1: difference vector and magnitudes.
	logic signed [32:0] d_c [3];
	logic [32:0]        mag_c [3];
	logic               v_s1;
	logic [32:0]        mag_s1 [3];
	logic [2:0]         neg_s1;
	pps_pkg::side_t     side_s1;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			d_c[i]   = {lpos[i][31], lpos[i]} - {hit[i][31], hit[i]};
			mag_c[i] = d_c[i][32] ? 33'(-d_c[i]) : 33'(d_c[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= in_v;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mag_s1  <= mag_c;
			side_s1 <= side_in;
			for (int i = 0; i < 3; i++) neg_s1[i] <= d_c[i][32];
		end
	end

	// Stage 2: shift so the largest magnitude lies in [2^29, 2^30).
	logic [32:0] mx_c;
	logic [5:0]  pos_c;
	logic [29:0] nm_c [3];
	logic        v_s2;
	logic [29:0] nm_s2 [3];
	logic [2:0]  neg_s2;
	logic        zero_s2;
	pps_pkg::side_t side_s2;

	always_comb begin
		mx_c = mag_s1[0];
		if (mag_s1[1] > mx_c) mx_c = mag_s1[1];
		if (mag_s1[2] > mx_c) mx_c = mag_s1[2];
		pos_c = pps_pkg::msb_pos(mx_c);
		for (int i = 0; i < 3; i++) begin
			if (pos_c >= 6'd29) nm_c[i] = 30'(mag_s1[i] >> (pos_c - 6'd29));
			else nm_c[i] = 30'(mag_s1[i] << (6'd29 - pos_c));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			nm_s2   <= nm_c;
			neg_s2  <= neg_s1;
			zero_s2 <= (mx_c == 33'd0);
			side_s2 <= side_s1;
		end
	end

	// Stage 3: squares.
	logic        v_s3;
	logic [59:0] sq_s3 [3];
	logic [29:0] nm_s3 [3];
	logic [2:0]  neg_s3;
	logic        zero_s3;
	pps_pkg::side_t side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (adv) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) sq_s3[i] <= 60'(nm_s2[i]) * 60'(nm_s2[i]);
			nm_s3   <= nm_s2;
			neg_s3  <= neg_s2;
			zero_s3 <= zero_s2;
			side_s3 <= side_s2;
		end
	end

	// Square root, one result bit per stage; entry 0 holds the sum of squares.
	logic           sq_v_s    [SQ_STEPS+1];
	logic [62:0]    sq_rem_s  [SQ_STEPS+1];
	logic [30:0]    sq_root_s [SQ_STEPS+1];
	logic [29:0]    sq_nm_s   [SQ_STEPS+1][3];
	logic [2:0]     sq_neg_s  [SQ_STEPS+1];
	logic           sq_zero_s [SQ_STEPS+1];
	pps_pkg::side_t sq_side_s [SQ_STEPS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) sq_v_s[0] <= 1'b0;
		else if (adv) sq_v_s[0] <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_rem_s[0]  <= 63'(sq_s3[0]) + 63'(sq_s3[1]) + 63'(sq_s3[2]);
			sq_root_s[0] <= '0;
			sq_nm_s[0]   <= nm_s3;
			sq_neg_s[0]  <= neg_s3;
			sq_zero_s[0] <= zero_s3;
			sq_side_s[0] <= side_s3;
		end
	end

	for (genvar j = 1; j <= SQ_STEPS; j++) begin : g_sqrt
		localparam int B = SQ_STEPS - j;
		logic [62:0] trial;
		assign trial = (63'(sq_root_s[j-1]) << (B + 1)) + (63'd1 << (2 * B));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sq_v_s[j] <= 1'b0;
			else if (adv) sq_v_s[j] <= sq_v_s[j-1];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				if (sq_rem_s[j-1] >= trial) begin
					sq_rem_s[j]  <= sq_rem_s[j-1] - trial;
					sq_root_s[j] <= sq_root_s[j-1] | (31'd1 << B);
				end else begin
					sq_rem_s[j]  <= sq_rem_s[j-1];
					sq_root_s[j] <= sq_root_s[j-1];
				end
				sq_nm_s[j]   <= sq_nm_s[j-1];
				sq_neg_s[j]  <= sq_neg_s[j-1];
				sq_zero_s[j] <= sq_zero_s[j-1];
				sq_side_s[j] <= sq_side_s[j-1];
			end
		end
	end

	// Division of each scaled magnitude by the length, one quotient bit per stage.
	logic           dv_v_s    [DIV_STEPS+1];
	logic [44:0]    dv_rem_s  [DIV_STEPS+1][3];
	logic [14:0]    dv_q_s    [DIV_STEPS+1][3];
	logic [30:0]    dv_len_s  [DIV_STEPS+1];
	logic [2:0]     dv_neg_s  [DIV_STEPS+1];
	logic           dv_zero_s [DIV_STEPS+1];
	pps_pkg::side_t dv_side_s [DIV_STEPS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dv_v_s[0] <= 1'b0;
		else if (adv) dv_v_s[0] <= sq_v_s[SQ_STEPS];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				dv_rem_s[0][i] <= {1'b0, sq_nm_s[SQ_STEPS][i], 14'd0}
					+ 45'(sq_root_s[SQ_STEPS] >> 1);
				dv_q_s[0][i]   <= '0;
			end
			dv_len_s[0]  <= sq_root_s[SQ_STEPS];
			dv_neg_s[0]  <= sq_neg_s[SQ_STEPS];
			dv_zero_s[0] <= sq_zero_s[SQ_STEPS];
			dv_side_s[0] <= sq_side_s[SQ_STEPS];
		end
	end

	for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_div
		localparam int B = DIV_STEPS - j;
		logic [44:0] dsub;
		assign dsub = 45'(dv_len_s[j-1]) << B;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_v_s[j] <= 1'b0;
			else if (adv) dv_v_s[j] <= dv_v_s[j-1];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				for (int i = 0; i < 3; i++) begin
					if (dv_rem_s[j-1][i] >= dsub) begin
						dv_rem_s[j][i] <= dv_rem_s[j-1][i] - dsub;
						dv_q_s[j][i]   <= dv_q_s[j-1][i] | (15'd1 << B);
					end else begin
						dv_rem_s[j][i] <= dv_rem_s[j-1][i];
						dv_q_s[j][i]   <= dv_q_s[j-1][i];
					end
				end
				dv_len_s[j]  <= dv_len_s[j-1];
				dv_neg_s[j]  <= dv_neg_s[j-1];
				dv_zero_s[j] <= dv_zero_s[j-1];
				dv_side_s[j] <= dv_side_s[j-1];
			end
		end
	end

	// Output stage: restore signs; a light sitting on the hit point gives a zero vector.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_v <= 1'b0;
		else if (adv) out_v <= dv_v_s[DIV_STEPS];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				if (dv_zero_s[DIV_STEPS]) dir[i] <= '0;
				else if (dv_neg_s[DIV_STEPS][i]) dir[i] <= -$signed({1'b0, dv_q_s[DIV_STEPS][i]});
				else dir[i] <= $signed({1'b0, dv_q_s[DIV_STEPS][i]});
			end
			side_out <= dv_side_s[DIV_STEPS];
		end
	end

endmodule

>>> hdl/pps_shade.sv
// Shading pipeline: reflection, diffuse and specular factors, colour scaling.
module pps_shade (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  logic          in_v,
	input  pps_pkg::q14_t dir [3],
	input  pps_pkg::side_t side_in,
	input  logic [7:0]    light_col [3],
	input  logic [16:0]   ratio,
	output logic          out_v,
	output logic [20:0]   col [3]
);

	// t1: V.N, N.L and light times surface colour.
	logic signed [33:0] vn_c, nl_c;
	logic               v_t1;
	logic signed [33:0] vn_t1, nl_t1;
	logic [15:0]        lcsc_t1 [3];
	pps_pkg::q14_t      dir_t1 [3];
	pps_pkg::side_t     side_t1;

	always_comb begin
		vn_c = side_in.view[0] * side_in.nrm[0] + side_in.view[1] * side_in.nrm[1]
			+ side_in.view[2] * side_in.nrm[2];
		nl_c = side_in.nrm[0] * dir[0] + side_in.nrm[1] * dir[1] + side_in.nrm[2] * dir[2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_t1 <= 1'b0;
		else if (adv) v_t1 <= in_v;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			vn_t1 <= vn_c;
			nl_t1 <= nl_c;
			for (int i = 0; i < 3; i++)
				lcsc_t1[i] <= 16'(light_col[i]) * 16'(side_in.surface[(2-i)*8 +: 8]);
			dir_t1  <= dir;
			side_t1 <= side_in;
		end
	end

	// t2: 2(V.N)N, brightness product, diffuse factor.
	logic               v_t2;
	logic signed [50:0] p2_t2 [3];
	logic [32:0]        lsr_t2 [3];
	logic [14:0]        diff_t2;
	pps_pkg::q14_t      dir_t2 [3];
	pps_pkg::side_t     side_t2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_t2 <= 1'b0;
		else if (adv) v_t2 <= v_t1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				p2_t2[i]  <= $signed({vn_t1, 1'b0}) * side_t1.nrm[i];
				lsr_t2[i] <= 33'(lcsc_t1[i]) * 33'(ratio);
			end
			diff_t2 <= pps_pkg::sat_factor(pps_pkg::FACT_W'(nl_t1));
			dir_t2  <= dir_t1;
			side_t2 <= side_t1;
		end
	end

	// t3: reflected ray, the Q.42 term rounded half away from zero.
	logic [50:0]        amag_c [3];
	logic [22:0]        rnd_c [3];
	logic signed [23:0] rs_c [3];
	logic signed [23:0] r_c [3];
	logic               v_t3;
	logic signed [23:0] r_t3 [3];
	logic [32:0]        lsr_t3 [3];
	logic [14:0]        diff_t3;
	pps_pkg::q14_t      dir_t3 [3];
	pps_pkg::side_t     side_t3;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			amag_c[i] = p2_t2[i][50] ? 51'(-p2_t2[i]) : 51'(p2_t2[i]);
			rnd_c[i]  = 23'((amag_c[i] + 51'd134217728) >> 28);
			rs_c[i]   = p2_t2[i][50] ? -$signed({1'b0, rnd_c[i]}) : $signed({1'b0, rnd_c[i]});
			r_c[i]    = 24'(side_t2.view[i]) - rs_c[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_t3 <= 1'b0;
		else if (adv) v_t3 <= v_t2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			r_t3    <= r_c;
			lsr_t3  <= lsr_t2;
			diff_t3 <= diff_t2;
			dir_t3  <= dir_t2;
			side_t3 <= side_t2;
		end
	end

	// t4: R.L.
	logic               v_t4;
	logic signed [41:0] rl_t4;
	logic [32:0]        lsr_t4 [3];
	logic [14:0]        diff_t4;
	pps_pkg::side_t     side_t4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_t4 <= 1'b0;
		else if (adv) v_t4 <= v_t3;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rl_t4   <= r_t3[0] * dir_t3[0] + r_t3[1] * dir_t3[1] + r_t3[2] * dir_t3[2];
			lsr_t4  <= lsr_t3;
			diff_t4 <= diff_t3;
			side_t4 <= side_t3;
		end
	end

	// t5 to t7: specular base and its cube.
	logic           v_t5, v_t6, v_t7;
	logic [14:0]    s_t5, s_t6;
	logic [29:0]    s2_t6;
	logic [44:0]    s3_t7;
	logic [32:0]    lsr_t5 [3], lsr_t6 [3], lsr_t7 [3];
	logic [14:0]    diff_t5, diff_t6, diff_t7;
	pps_pkg::side_t side_t5, side_t6, side_t7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_t5 <= 1'b0;
			v_t6 <= 1'b0;
			v_t7 <= 1'b0;
		end else if (adv) begin
			v_t5 <= v_t4;
			v_t6 <= v_t5;
			v_t7 <= v_t6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			s_t5    <= pps_pkg::sat_factor(rl_t4);
			s_t6    <= s_t5;
			s2_t6   <= 30'(s_t5) * 30'(s_t5);
			s3_t7   <= 45'(s2_t6) * 45'(s_t6);
			lsr_t5  <= lsr_t4;
			lsr_t6  <= lsr_t5;
			lsr_t7  <= lsr_t6;
			diff_t5 <= diff_t4;
			diff_t6 <= diff_t5;
			diff_t7 <= diff_t6;
			side_t5 <= side_t4;
			side_t6 <= side_t5;
			side_t7 <= side_t6;
		end
	end

	// t8: combined light factor, zero in shadow.
	logic           v_t8;
	logic [15:0]    f_t8;
	logic [32:0]    lsr_t8 [3];
	logic [23:0]    amb_t8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_t8 <= 1'b0;
		else if (adv) v_t8 <= v_t7;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (side_t7.shadow) f_t8 <= '0;
			else f_t8 <= 16'(diff_t7) + 16'((s3_t7 + 45'd134217728) >> 28);
			lsr_t8 <= lsr_t7;
			amb_t8 <= side_t7.ambient;
		end
	end

	// t9 to t12: product, rounding, division by 255 through the reciprocal, ambient.
	logic        v_t9, v_t10, v_t11;
	logic [48:0] p_t9 [3];
	logic [27:0] tq_t10 [3];
	logic [59:0] m_t11 [3];
	logic [23:0] amb_t9, amb_t10, amb_t11;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_t9  <= 1'b0;
			v_t10 <= 1'b0;
			v_t11 <= 1'b0;
			out_v <= 1'b0;
		end else if (adv) begin
			v_t9  <= v_t8;
			v_t10 <= v_t9;
			v_t11 <= v_t10;
			out_v <= v_t11;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				p_t9[i]   <= 49'(lsr_t8[i]) * 49'(f_t8);
				tq_t10[i] <= 28'(({1'b0, p_t9[i]} + pps_pkg::COL_ROUND) >> 22);
				m_t11[i]  <= 60'(tq_t10[i]) * 60'(pps_pkg::RECIP_255);
				col[i]    <= 21'(m_t11[i] >> pps_pkg::RECIP_SHIFT)
					+ 21'({amb_t11[(2-i)*8 +: 8], 8'd0});
			end
			amb_t9  <= amb_t8;
			amb_t10 <= amb_t9;
			amb_t11 <= amb_t10;
		end
	end

endmodule

>>> hdl/pps_clamp.sv
// Overflow scaling: a pipelined divider brings the brightest channel down to 255.0.
module pps_clamp (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        adv,
	input  logic        in_v,
	input  logic [20:0] col [3],
	output logic        out_v,
	output logic [15:0] rgb [3]
);

	localparam int DIV_STEPS = 16;

	logic [20:0] mx_c;
	logic        v_s1;
	logic [20:0] c_s1 [3];
	logic [20:0] mx_s1;

	always_comb begin
		mx_c = col[0];
		if (col[1] > mx_c) mx_c = col[1];
		if (col[2] > mx_c) mx_c = col[2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= in_v;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c_s1  <= col;
			mx_s1 <= mx_c;
		end
	end

	logic        dv_v_s   [DIV_STEPS+1];
	logic [37:0] dv_rem_s [DIV_STEPS+1][3];
	logic [15:0] dv_q_s   [DIV_STEPS+1][3];
	logic [15:0] dv_c_s   [DIV_STEPS+1][3];
	logic [20:0] dv_mx_s  [DIV_STEPS+1];
	logic        dv_big_s [DIV_STEPS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dv_v_s[0] <= 1'b0;
		else if (adv) dv_v_s[0] <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				dv_rem_s[0][i] <= 38'(c_s1[i]) * 38'(pps_pkg::FULL_Q8) + 38'(mx_s1 >> 1);
				dv_q_s[0][i]   <= '0;
				dv_c_s[0][i]   <= c_s1[i][15:0];
			end
			dv_mx_s[0]  <= mx_s1;
			dv_big_s[0] <= (mx_s1 >= 21'(pps_pkg::FULL_Q8));
		end
	end

	for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_div
		localparam int B = DIV_STEPS - j;
		logic [37:0] dsub;
		assign dsub = 38'(dv_mx_s[j-1]) << B;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_v_s[j] <= 1'b0;
			else if (adv) dv_v_s[j] <= dv_v_s[j-1];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				for (int i = 0; i < 3; i++) begin
					if (dv_rem_s[j-1][i] >= dsub) begin
						dv_rem_s[j][i] <= dv_rem_s[j-1][i] - dsub;
						dv_q_s[j][i]   <= dv_q_s[j-1][i] | (16'd1 << B);
					end else begin
						dv_rem_s[j][i] <= dv_rem_s[j-1][i];
						dv_q_s[j][i]   <= dv_q_s[j-1][i];
					end
				end
				dv_c_s[j]   <= dv_c_s[j-1];
				dv_mx_s[j]  <= dv_mx_s[j-1];
				dv_big_s[j] <= dv_big_s[j-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_v <= 1'b0;
		else if (adv) out_v <= dv_v_s[DIV_STEPS];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++)
				rgb[i] <= dv_big_s[DIV_STEPS] ? dv_q_s[DIV_STEPS][i] : dv_c_s[DIV_STEPS][i];
		end
	end

endmodule

>>> hdl/phong_point_light_shade_core.sv
// Top level of the point-light Phong shading core with its register port.
`include "phong_point_light_shade_core_assert.svh"

// The core shades one ray hit point against one point light and takes a new item
// on every clock cycle while the output is not stalled. The light direction unit
// extracts the length of the light vector one root bit per stage (31 stages) and
// then divides each component by it one quotient bit per stage (15 stages); the
// 16-stage divider that follows rescales an overflowing colour. Every stage
// moves only when the output register is empty or being read, so a stall at
// the output holds the whole pipeline and drops ready at the input in the same
// cycle. The light position, colour and ratio must be written through the
// register port only while no item is in flight; the core does not enforce
// this. A ratio above 1.0 acts as 1.0.
module phong_point_light_shade_core (
	input  logic        clk,
	input  logic        arst_n,
	pps_hit_if.sink     hit_in,
	pps_shade_if.source shade_out,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// Configuration registers.
	logic signed [31:0] light_pos_q [3];
	logic [7:0]         light_col_q [3];
	logic [16:0]        light_ratio_q;
	logic [16:0]        ratio_eff;
	logic               cfg_wr;
	pps_pkg::reg_idx_t  cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = pps_pkg::reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			light_pos_q[0] <= '0;
			light_pos_q[1] <= '0;
			light_pos_q[2] <= '0;
			light_col_q[0] <= 8'd255;
			light_col_q[1] <= 8'd255;
			light_col_q[2] <= 8'd255;
			light_ratio_q  <= pps_pkg::RATIO_MAX;
		end else if (cfg_wr) begin
			case (cfg_idx)
				pps_pkg::REG_LIGHT_POS_X: light_pos_q[0] <= pwdata;
				pps_pkg::REG_LIGHT_POS_Y: light_pos_q[1] <= pwdata;
				pps_pkg::REG_LIGHT_POS_Z: light_pos_q[2] <= pwdata;
				pps_pkg::REG_LIGHT_RED:   light_col_q[0] <= pwdata[7:0];
				pps_pkg::REG_LIGHT_GREEN: light_col_q[1] <= pwdata[7:0];
				pps_pkg::REG_LIGHT_BLUE:  light_col_q[2] <= pwdata[7:0];
				pps_pkg::REG_LIGHT_RATIO: light_ratio_q  <= pwdata[16:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			pps_pkg::REG_LIGHT_POS_X: prdata = light_pos_q[0];
			pps_pkg::REG_LIGHT_POS_Y: prdata = light_pos_q[1];
			pps_pkg::REG_LIGHT_POS_Z: prdata = light_pos_q[2];
			pps_pkg::REG_LIGHT_RED:   prdata = 32'(light_col_q[0]);
			pps_pkg::REG_LIGHT_GREEN: prdata = 32'(light_col_q[1]);
			pps_pkg::REG_LIGHT_BLUE:  prdata = 32'(light_col_q[2]);
			pps_pkg::REG_LIGHT_RATIO: prdata = 32'(light_ratio_q);
			default:                  prdata = '0;
		endcase
	end

	assign ratio_eff = (light_ratio_q > pps_pkg::RATIO_MAX) ? pps_pkg::RATIO_MAX
		: light_ratio_q;

	// Pipeline advance: the whole pipeline moves unless the output register is stuck.
	logic adv;
	assign adv          = !shade_out.valid || shade_out.ready;
	assign hit_in.ready = adv;

	logic signed [31:0] hit_c [3];
	pps_pkg::side_t     side_c;

	assign hit_c[0] = hit_in.hit_x;
	assign hit_c[1] = hit_in.hit_y;
	assign hit_c[2] = hit_in.hit_z;

	always_comb begin
		side_c.nrm[0]  = hit_in.normal_x;
		side_c.nrm[1]  = hit_in.normal_y;
		side_c.nrm[2]  = hit_in.normal_z;
		side_c.view[0] = hit_in.view_x;
		side_c.view[1] = hit_in.view_y;
		side_c.view[2] = hit_in.view_z;
		side_c.surface = hit_in.surface_rgb;
		side_c.ambient = hit_in.ambient_rgb;
		side_c.shadow  = hit_in.in_shadow;
	end

	logic           ld_v;
	pps_pkg::q14_t  ld_dir [3];
	pps_pkg::side_t ld_side;

	pps_ldir u_ldir (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_v     (hit_in.valid),
		.hit      (hit_c),
		.lpos     (light_pos_q),
		.side_in  (side_c),
		.out_v    (ld_v),
		.dir      (ld_dir),
		.side_out (ld_side)
	);

	logic        sh_v;
	logic [20:0] sh_col [3];

	pps_shade u_shade (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_v      (ld_v),
		.dir       (ld_dir),
		.side_in   (ld_side),
		.light_col (light_col_q),
		.ratio     (ratio_eff),
		.out_v     (sh_v),
		.col       (sh_col)
	);

	logic        cl_v;
	logic [15:0] cl_rgb [3];

	pps_clamp u_clamp (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.in_v   (sh_v),
		.col    (sh_col),
		.out_v  (cl_v),
		.rgb    (cl_rgb)
	);

	assign shade_out.valid     = cl_v;
	assign shade_out.out_red   = cl_rgb[0];
	assign shade_out.out_green = cl_rgb[1];
	assign shade_out.out_blue  = cl_rgb[2];

	// All three channels of the output item sit at or below 255.0.
	logic out_in_range;
	assign out_in_range = (shade_out.out_red <= pps_pkg::FULL_Q8)
		&& (shade_out.out_green <= pps_pkg::FULL_Q8)
		&& (shade_out.out_blue <= pps_pkg::FULL_Q8);

	// A waiting result must hold the input side closed.
	`PPS_ASSERT_IMP(a_stall_holds_input, shade_out.valid && !shade_out.ready, !hit_in.ready)
	// The overflow scaling never lets a channel exceed 255.0.
	`PPS_ASSERT_IMP(a_out_in_range, shade_out.valid, out_in_range)
	// A ratio write lands in its register.
	`PPS_ASSERT_NXT(a_ratio_write, cfg_wr && (cfg_idx == pps_pkg::REG_LIGHT_RATIO), light_ratio_q == $past(pwdata[16:0]))

endmodule

>>> tb/pps_shade_checker.sv
// Checker that predicts each shaded colour from the hit stream and compares the outputs.
module pps_shade_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        hit_valid,
	input  logic        hit_ready,
	input  logic [31:0] hit_x,
	input  logic [31:0] hit_y,
	input  logic [31:0] hit_z,
	input  logic [15:0] normal_x,
	input  logic [15:0] normal_y,
	input  logic [15:0] normal_z,
	input  logic [15:0] view_x,
	input  logic [15:0] view_y,
	input  logic [15:0] view_z,
	input  logic [23:0] surface_rgb,
	input  logic [23:0] ambient_rgb,
	input  logic        in_shadow,
	input  logic        shade_valid,
	input  logic        shade_ready,
	input  logic [15:0] out_red,
	input  logic [15:0] out_green,
	input  logic [15:0] out_blue,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
	} colour_t;

	logic [31:0] light_pos [3];
	logic [7:0]  light_col [3];
	logic [16:0] light_ratio;
	colour_t     expected_colours [$];

	function automatic longint isqrt(input longint x);
		longint res, bit_v;
		res = 0;
		bit_v = 64'sd1 <<< 62;
		while (bit_v > x) bit_v = bit_v >>> 2;
		while (bit_v != 0) begin
			if (x >= res + bit_v) begin
				x = x - (res + bit_v);
				res = (res >>> 1) + bit_v;
			end else begin
				res = res >>> 1;
			end
			bit_v = bit_v >>> 2;
		end
		return res;
	endfunction

	function automatic longint clamp_factor(input longint d);
		longint f;
		if (d <= 0) return 0;
		f = (d + 8192) >>> 14;
		return (f > 16384) ? 16384 : f;
	endfunction

	function automatic longint round_away(input longint x);
		if (x < 0) return -((-x + (64'sd1 <<< 27)) >>> 28);
		return (x + (64'sd1 <<< 27)) >>> 28;
	endfunction

	function automatic colour_t shade_colour(input logic [31:0] hp [3],
			input logic [15:0] nv [3], input logic [15:0] vv [3],
			input logic [23:0] surf, input logic [23:0] amb, input logic shadow);
		longint d [3], mag [3], u [3], n [3], v [3], r [3];
		longint m, sum, len, vn, nl, rl, diff, s, spec, f, ratio, mx, q;
		longint unsigned p, den;
		longint c [3];
		colour_t res;
		m = 0; vn = 0; nl = 0; rl = 0; mx = 0;
		for (int i = 0; i < 3; i++) begin
			d[i] = longint'($signed(light_pos[i])) - longint'($signed(hp[i]));
			n[i] = longint'($signed(nv[i]));
			v[i] = longint'($signed(vv[i]));
			mag[i] = d[i] < 0 ? -d[i] : d[i];
			if (mag[i] > m) m = mag[i];
		end
		if (m == 0) begin
			for (int i = 0; i < 3; i++) u[i] = 0;
		end else begin
			while (m >= (64'sd1 <<< 30)) begin
				m = m >>> 1;
				for (int i = 0; i < 3; i++) mag[i] = mag[i] >>> 1;
			end
			while (m < (64'sd1 <<< 29)) begin
				m = m <<< 1;
				for (int i = 0; i < 3; i++) mag[i] = mag[i] <<< 1;
			end
			sum = 0;
			for (int i = 0; i < 3; i++) sum += mag[i] * mag[i];
			len = isqrt(sum);
			for (int i = 0; i < 3; i++) begin
				q = (mag[i] * 16384 + len / 2) / len;
				u[i] = d[i] < 0 ? -q : q;
			end
		end
		for (int i = 0; i < 3; i++) vn += v[i] * n[i];
		for (int i = 0; i < 3; i++) r[i] = v[i] - round_away(2 * vn * n[i]);
		for (int i = 0; i < 3; i++) begin
			nl += n[i] * u[i];
			rl += r[i] * u[i];
		end
		diff = clamp_factor(nl);
		s = clamp_factor(rl);
		spec = (s * s * s + (64'sd1 <<< 27)) >>> 28;
		f = shadow ? 0 : diff + spec;
		ratio = (light_ratio > 17'd65536) ? 65536 : longint'(light_ratio);
		den = 64'd255 << 22;
		for (int i = 0; i < 3; i++) begin
			p = longint'(light_col[i]) * longint'(surf[16-8*i +: 8]) * ratio * f;
			c[i] = longint'((p + den / 2) / den) + longint'(amb[16-8*i +: 8]) * 256;
			if (c[i] > mx) mx = c[i];
		end
		if (mx >= 65280)
			for (int i = 0; i < 3; i++) c[i] = (c[i] * 65280 + mx / 2) / mx;
		res.red = c[0][15:0];
		res.green = c[1][15:0];
		res.blue = c[2][15:0];
		return res;
	endfunction

	assign pending = expected_colours.size();

	always @(posedge clk or negedge arst_n) begin
		logic [31:0] hp [3];
		logic [15:0] nv [3];
		logic [15:0] vv [3];
		colour_t got, want;
		if (!arst_n) begin
			light_pos[0] <= '0; light_pos[1] <= '0; light_pos[2] <= '0;
			light_col[0] <= 8'd255; light_col[1] <= 8'd255; light_col[2] <= 8'd255;
			light_ratio <= 17'd65536;
			fail_count <= 0;
			expected_colours.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (pps_pkg::reg_idx_t'(paddr[4:2]))
				pps_pkg::REG_LIGHT_POS_X: light_pos[0] <= pwdata;
				pps_pkg::REG_LIGHT_POS_Y: light_pos[1] <= pwdata;
				pps_pkg::REG_LIGHT_POS_Z: light_pos[2] <= pwdata;
				pps_pkg::REG_LIGHT_RED:   light_col[0] <= pwdata[7:0];
				pps_pkg::REG_LIGHT_GREEN: light_col[1] <= pwdata[7:0];
				pps_pkg::REG_LIGHT_BLUE:  light_col[2] <= pwdata[7:0];
				pps_pkg::REG_LIGHT_RATIO: light_ratio <= pwdata[16:0];
				default: ;
				endcase
			end
			if (hit_valid && hit_ready) begin
				hp[0] = hit_x; hp[1] = hit_y; hp[2] = hit_z;
				nv[0] = normal_x; nv[1] = normal_y; nv[2] = normal_z;
				vv[0] = view_x; vv[1] = view_y; vv[2] = view_z;
				expected_colours.push_back(shade_colour(hp, nv, vv, surface_rgb,
					ambient_rgb, in_shadow));
			end
			if (shade_valid && shade_ready) begin
				got = '{out_red, out_green, out_blue};
				if (expected_colours.size() == 0) begin
					$display("%0t: expected none actual %h", $time, got);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_colours.pop_front();
					if (got !== want) begin
						$display("%0t: expected %h actual %h", $time, want, got);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

>>> tb/phong_point_light_shade_core_tb.sv
// Top of the shading core testbench: clock, reset, stimulus and verdict.
module phong_point_light_shade_core_tb;

	// The drain wait allows well beyond the latency of the core.
	localparam int DRAIN_CYCLES = 200;
	localparam int CYCLE_LIMIT  = 400000;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite, pready;
	logic [4:0]  paddr;
	logic [31:0] pwdata, prdata;
	int          fail_count, pending, cycle_count;
	bit          stall_now;

	pps_hit_if   hit_ch ();
	pps_shade_if shade_ch ();

	phong_point_light_shade_core DUT (
		.clk(clk), .arst_n(arst_n), .hit_in(hit_ch.sink), .shade_out(shade_ch.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	pps_shade_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.hit_valid(hit_ch.valid), .hit_ready(hit_ch.ready),
		.hit_x(hit_ch.hit_x), .hit_y(hit_ch.hit_y), .hit_z(hit_ch.hit_z),
		.normal_x(hit_ch.normal_x), .normal_y(hit_ch.normal_y),
		.normal_z(hit_ch.normal_z), .view_x(hit_ch.view_x), .view_y(hit_ch.view_y),
		.view_z(hit_ch.view_z), .surface_rgb(hit_ch.surface_rgb),
		.ambient_rgb(hit_ch.ambient_rgb), .in_shadow(hit_ch.in_shadow),
		.shade_valid(shade_ch.valid), .shade_ready(shade_ch.ready),
		.out_red(shade_ch.out_red), .out_green(shade_ch.out_green),
		.out_blue(shade_ch.out_blue), .psel(psel), .penable(penable),
		.pwrite(pwrite), .pready(pready), .paddr(paddr), .pwdata(pwdata),
		.fail_count(fail_count), .pending(pending)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// The cycle counter ends a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// The receiver stalls in its own pattern: quiet stretches, then spells of random stalls.
	always @(negedge clk) begin
		if (($urandom_range(0, 63)) == 0) begin
			stall_now <= ~stall_now;
		end
		shade_ch.ready <= stall_now ? ($urandom_range(0, 2) != 0) : 1'b1;
	end

	// A register write: setup cycle, then access cycle.
	task automatic write_reg(input pps_pkg::reg_idx_t idx, input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {idx, 2'b00}; pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	task automatic set_light(input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] z, input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b, input logic [16:0] ratio);
		write_reg(pps_pkg::REG_LIGHT_POS_X, x);
		write_reg(pps_pkg::REG_LIGHT_POS_Y, y);
		write_reg(pps_pkg::REG_LIGHT_POS_Z, z);
		write_reg(pps_pkg::REG_LIGHT_RED, {24'd0, r});
		write_reg(pps_pkg::REG_LIGHT_GREEN, {24'd0, g});
		write_reg(pps_pkg::REG_LIGHT_BLUE, {24'd0, b});
		write_reg(pps_pkg::REG_LIGHT_RATIO, {15'd0, ratio});
	endtask

	// Hold one item on the channel until the core takes it.
	task automatic send_hit(input logic [31:0] hx, input logic [31:0] hy,
			input logic [31:0] hz, input logic [15:0] nx, input logic [15:0] ny,
			input logic [15:0] nz, input logic [15:0] vx, input logic [15:0] vy,
			input logic [15:0] vz, input logic [23:0] surf, input logic [23:0] amb,
			input logic shadow);
		hit_ch.valid <= 1'b1;
		hit_ch.hit_x <= hx; hit_ch.hit_y <= hy; hit_ch.hit_z <= hz;
		hit_ch.normal_x <= nx; hit_ch.normal_y <= ny; hit_ch.normal_z <= nz;
		hit_ch.view_x <= vx; hit_ch.view_y <= vy; hit_ch.view_z <= vz;
		hit_ch.surface_rgb <= surf; hit_ch.ambient_rgb <= amb;
		hit_ch.in_shadow <= shadow;
		do @(posedge clk); while (!hit_ch.ready);
		@(negedge clk);
	endtask

	task automatic idle_sender(input int cycles);
		hit_ch.valid <= 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	// Waits for every colour to arrive, then lets the pipeline settle.
	task automatic drain();
		idle_sender(0);
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	function automatic logic [15:0] rand_comp();
		// Mostly in the unit range, sometimes anywhere in the 16-bit field.
		if ($urandom_range(0, 7) == 0) return 16'($urandom);
		return 16'($signed($urandom_range(0, 32768)) - 16384);
	endfunction

	// Random vector: a unit axis, a unit diagonal in the x-y plane, or random components.
	task automatic rand_unit(output logic [15:0] a, output logic [15:0] b,
			output logic [15:0] c);
		int k;
		k = $urandom_range(0, 3);
		a = rand_comp(); b = rand_comp(); c = rand_comp();
		if (k == 0) begin
			a = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384; b = 0; c = 0;
		end else if (k == 1) begin
			a = 16'sd11585; b = $urandom_range(0, 1) ? 16'sd11585 : -16'sd11585; c = 0;
		end
	endtask

	function automatic logic [31:0] rand_pos();
		case ($urandom_range(0, 3))
		0: return $urandom;
		1: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
		2: return 32'($signed($urandom_range(0, 200)) - 100) << 16;
		default: return 32'($urandom_range(0, 15));
		endcase
	endfunction

	task automatic random_items(input int count);
		logic [15:0] n0, n1, n2, v0, v1, v2;
		int burst;
		burst = 0;
		for (int i = 0; i < count; i++) begin
			if (burst == 0) begin
				burst = $urandom_range(1, 40);
				if ($urandom_range(0, 2) == 0) idle_sender($urandom_range(1, 12));
			end
			burst--;
			rand_unit(n0, n1, n2);
			rand_unit(v0, v1, v2);
			send_hit(rand_pos(), rand_pos(), rand_pos(), n0, n1, n2, v0, v1, v2,
				24'($urandom), 24'($urandom), $urandom_range(0, 5) == 0);
		end
	endtask

	initial begin
		hit_ch.valid = 1'b0;
		hit_ch.hit_x = '0; hit_ch.hit_y = '0; hit_ch.hit_z = '0;
		hit_ch.normal_x = '0; hit_ch.normal_y = '0; hit_ch.normal_z = '0;
		hit_ch.view_x = '0; hit_ch.view_y = '0; hit_ch.view_z = '0;
		hit_ch.surface_rgb = '0; hit_ch.ambient_rgb = '0; hit_ch.in_shadow = 1'b0;
		shade_ch.ready = 1'b1;
		stall_now = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		cycle_count = 0;
		arst_n = 1'b0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed items under the reset light: at the origin, white, full ratio.
		// Light at the hit point gives no direction, so only ambient remains.
		send_hit(0, 0, 0, 16'sd16384, 0, 0, -16'sd16384, 0, 0, 24'hFFFFFF, 24'h000000, 0);
		// Light straight along the normal; bright surface overflows and is rescaled.
		send_hit(32'hFFF0_0000, 0, 0, 16'sd16384, 0, 0, -16'sd16384, 0, 0,
			24'hFFFFFF, 24'hFFFFFF, 0);
		// Same geometry in shadow: ambient alone.
		send_hit(32'hFFF0_0000, 0, 0, 16'sd16384, 0, 0, -16'sd16384, 0, 0,
			24'hFFFFFF, 24'h804020, 1);
		// Field extremes of the position and of the vector components.
		send_hit(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 16'h8000, 16'h7FFF,
			16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 24'hFFFFFF, 24'hFFFFFF, 0);
		send_hit(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF, 16'h0001,
			16'h0000, 16'h0000, 16'h0001, 16'hFFFF, 24'h000000, 24'h000000, 0);
		// Light behind the surface: diffuse clamps at zero.
		send_hit(32'h0010_0000, 0, 0, 16'sd16384, 0, 0, 16'sd16384, 0, 0,
			24'h123456, 24'h010203, 0);
		// Over-long vectors saturate the diffuse factor at one.
		send_hit(0, 32'hFF00_0000, 0, 0, 16'sd32767, 0, 0, 16'sd32767, 0,
			24'h406080, 24'h000000, 0);
		drain();

		// Light at the far corner, coloured and dimmed; ratio above one next.
		set_light(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 8'd0, 8'd128, 8'd255,
			17'd0);
		send_hit(0, 0, 0, 16'sd9459, -16'sd9459, 16'sd9459, -16'sd16384, 0, 0,
			24'hFFFFFF, 24'h102030, 0);
		drain();
		set_light(32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000, 8'd200, 8'd1, 8'd77,
			17'h1FFFF);
		random_items(300);
		// The sender waits here for every colour before going on.
		drain();
		set_light(rand_pos(), rand_pos(), rand_pos(), 8'($urandom), 8'($urandom),
			8'($urandom), 17'($urandom_range(0, 65536)));
		random_items(350);
		drain();
		set_light(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 8'd255, 8'd255, 8'd0,
			17'd32768);
		random_items(350);
		drain();
		set_light(0, 0, 0, 8'd255, 8'd255, 8'd255, 17'd65536);
		random_items(350);
		drain();

		if (fail_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
